FILE: hw/rtl/spi_master_ring_buffer_cs_core_assert.svh
// Assertion macros for the SPI master ring buffer and chip-select core
`ifndef SPI_MASTER_RING_BUFFER_CS_CORE_ASSERT_SVH
`define SPI_MASTER_RING_BUFFER_CS_CORE_ASSERT_SVH

// Condition in the same cycle implies consequence in the same cycle
`define SMRB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies consequence in the next cycle
`define SMRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/smrb_pkg.sv
// Shared constants and types for the SPI master ring buffer and chip-select core
`default_nettype none

package smrb_pkg;

    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 2;
    localparam int TX_DEPTH_DEF = 16;
    localparam int RX_DEPTH_DEF = 16;

    // Input word layout (tdata), lowest bit first
    localparam int IN_TX_BYTE_LSB  = 0;
    localparam int IN_RX_READY_BIT = 8;
    localparam int IN_RX_BYTE_LSB  = 9;
    localparam int IN_TX_READY_BIT = 17;
    localparam int S_TDATA_W       = 24;

    // Output word layout (tdata), lowest bit first
    localparam int OUT_WR_ACC_BIT    = 0;
    localparam int OUT_RD_VALID_BIT  = 1;
    localparam int OUT_RD_DATA_LSB   = 2;
    localparam int OUT_SND_VALID_BIT = 10;
    localparam int OUT_SND_DATA_LSB  = 11;
    localparam int OUT_DROP_BIT      = 19;
    localparam int OUT_CS_BIT        = 20;
    localparam int OUT_USED_W        = 21;
    localparam int M_TDATA_W         = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH    = 2'd0,
        KIND_READ    = 2'd1,
        KIND_SERVICE = 2'd2
    } kind_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spi_master_ring_buffer_cs_core.sv
// SPI master transmit/receive ring buffers with chip-select control
//
//   channel  dir  tdata                                    tuser  tlast
//   s_*      in   tx_byte, rx_ready, rx_byte, tx_ready      kind   tx_last
//   m_*      out  write_accepted, read_valid, read_data,    -      -
//                 send_valid, send_data, rx_dropped,
//                 chip_select
//
// One word per cycle: each accepted word is resolved in the cycle it is taken
// and its result lands in the output register on that edge.
// Each ring is a one-write, one-read memory; the read register is refreshed
// every cycle from the next tail with write-through forwarding.
// Reset clears pointers, send enable (to 1) and chip select (to inactive);
// no clearing pass, ring contents stay as they are.
// A stalled output holds its word; s_tready drops only while it waits.
`default_nettype none
`include "spi_master_ring_buffer_cs_core_assert.svh"

module spi_master_ring_buffer_cs_core #(
    parameter int TX_DEPTH = smrb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = smrb_pkg::RX_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tx_byte[7:0], rx_ready[8], rx_byte[16:9], tx_ready[17], zero pad
    input  wire logic [smrb_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  wire logic [smrb_pkg::KIND_W-1:0]    s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // write_accepted[0], read_valid[1], read_data[9:2], send_valid[10],
    // send_data[18:11], rx_dropped[19], chip_select[20], zero pad
    output logic [smrb_pkg::M_TDATA_W-1:0]      m_tdata
);
    import smrb_pkg::*;

    localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam logic [TX_PW-1:0] TX_LAST_IDX = TX_PW'(TX_DEPTH - 1);
    localparam logic [RX_PW-1:0] RX_LAST_IDX = RX_PW'(RX_DEPTH - 1);

    // Ring storage and pointers
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [TX_PW-1:0]  tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_PW-1:0]  rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_PW-1:0]  tx_head_inc, tx_tail_inc;
    logic [RX_PW-1:0]  rx_head_inc, rx_tail_inc;
    logic [BYTE_W-1:0] tx_rd_reg, rx_rd_reg;

    logic send_en_reg, send_en_next;
    logic cs_reg, cs_next;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    // Decoded item and ring status
    logic              take;
    kind_t             kind;
    logic [BYTE_W-1:0] tx_byte, rx_byte;
    logic              rx_ready, tx_ready;
    logic              tx_empty, tx_full, rx_empty, rx_full;
    logic              tx_wr, tx_rd, rx_wr, rx_rd, rx_drop, send_stop;
    logic [M_TDATA_W-1:0] result;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    assign kind     = kind_t'(s_tuser);
    assign tx_byte  = s_tdata[IN_TX_BYTE_LSB +: BYTE_W];
    assign rx_ready = s_tdata[IN_RX_READY_BIT];
    assign rx_byte  = s_tdata[IN_RX_BYTE_LSB +: BYTE_W];
    assign tx_ready = s_tdata[IN_TX_READY_BIT];

    // Wrap pointers at the ring depth
    assign tx_head_inc = (tx_head_reg == TX_LAST_IDX) ? '0 : tx_head_reg + TX_PW'(1);
    assign tx_tail_inc = (tx_tail_reg == TX_LAST_IDX) ? '0 : tx_tail_reg + TX_PW'(1);
    assign rx_head_inc = (rx_head_reg == RX_LAST_IDX) ? '0 : rx_head_reg + RX_PW'(1);
    assign rx_tail_inc = (rx_tail_reg == RX_LAST_IDX) ? '0 : rx_tail_reg + RX_PW'(1);

    assign tx_empty = (tx_head_reg == tx_tail_reg);
    assign tx_full  = (tx_head_inc == tx_tail_reg);
    assign rx_empty = (rx_head_reg == rx_tail_reg);
    assign rx_full  = (rx_head_inc == rx_tail_reg);

    // Decide the ring actions for the word being taken
    always_comb
    begin
        tx_wr     = 1'b0;
        tx_rd     = 1'b0;
        rx_wr     = 1'b0;
        rx_rd     = 1'b0;
        rx_drop   = 1'b0;
        send_stop = 1'b0;
        send_en_next = send_en_reg;
        cs_next      = cs_reg;
        if (take)
        begin
            case (kind)
                KIND_PUSH:
                begin
                    cs_next = 1'b0;
                    tx_wr   = !tx_full;
                    if (s_tlast)
                    begin
                        send_en_next = 1'b1;
                    end
                end
                KIND_READ:
                begin
                    rx_rd = !rx_empty;
                end
                KIND_SERVICE:
                begin
                    rx_wr   = rx_ready && !rx_full;
                    rx_drop = rx_ready && rx_full;
                    if (tx_ready && send_en_reg)
                    begin
                        tx_rd     = !tx_empty;
                        send_stop = tx_empty;
                    end
                    if (send_stop)
                    begin
                        send_en_next = 1'b0;
                        cs_next      = 1'b1;
                    end
                end
                default:
                begin
                    cs_next = cs_reg;
                end
            endcase
        end
    end

    assign tx_head_next = tx_wr ? tx_head_inc : tx_head_reg;
    assign tx_tail_next = tx_rd ? tx_tail_inc : tx_tail_reg;
    assign rx_head_next = rx_wr ? rx_head_inc : rx_head_reg;
    assign rx_tail_next = rx_rd ? rx_tail_inc : rx_tail_reg;

    // Assemble the result word
    always_comb
    begin
        result = '0;
        result[OUT_WR_ACC_BIT]    = tx_wr;
        result[OUT_RD_VALID_BIT]  = rx_rd;
        result[OUT_RD_DATA_LSB +: BYTE_W]  = rx_rd ? rx_rd_reg : '0;
        result[OUT_SND_VALID_BIT] = tx_rd;
        result[OUT_SND_DATA_LSB +: BYTE_W] = tx_rd ? tx_rd_reg : '0;
        result[OUT_DROP_BIT]      = rx_drop;
        result[OUT_CS_BIT]        = cs_next;
    end

    // Hold pointers, enable and chip select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            send_en_reg  <= 1'b1;
            cs_reg       <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            send_en_reg <= send_en_next;
            cs_reg      <= cs_next;
            if (s_tready)
            begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    // Load the output word when the output stage is free
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_tdata_reg <= result;
        end
    end

    // Write the rings
    always_ff @(posedge clk)
    begin
        if (tx_wr)
        begin
            tx_mem[tx_head_reg] <= tx_byte;
        end
        if (rx_wr)
        begin
            rx_mem[rx_head_reg] <= rx_byte;
        end
    end

    // Prefetch the byte at the next tail, forwarding a write to that slot
    always_ff @(posedge clk)
    begin
        if (tx_wr && (tx_head_reg == tx_tail_next))
        begin
            tx_rd_reg <= tx_byte;
        end
        else
        begin
            tx_rd_reg <= tx_mem[tx_tail_next];
        end
        if (rx_wr && (rx_head_reg == rx_tail_next))
        begin
            rx_rd_reg <= rx_byte;
        end
        else
        begin
            rx_rd_reg <= rx_mem[rx_tail_next];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on ring and chip-select behavior
    `SMRB_ASSERT_NEXT(a_tx_push_fills, tx_wr, !tx_empty, "tx ring empty after push")
    `SMRB_ASSERT_NEXT(a_rx_store_fills, rx_wr, !rx_empty, "rx ring empty after store")
    `SMRB_ASSERT_NEXT(a_stop_raises_cs, send_stop, cs_reg && !send_en_reg,
        "send stop did not raise chip select")
    `SMRB_ASSERT_SAME(a_no_take_on_stall, m_tvalid_reg && !m_tready, !take,
        "word taken while output stalled")

endmodule

`default_nettype wire

FILE: verif/spi_master_ring_buffer_cs_core_tb.sv
// Self-checking stream testbench for the SPI master ring buffer and chip-select core
module spi_master_ring_buffer_cs_core_tb;

    import smrb_pkg::*;

    // Unused command code; the core must ignore it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int TX_RING_DEPTH = TX_DEPTH_DEF;
    localparam int RX_RING_DEPTH = RX_DEPTH_DEF;
    localparam int RANDOM_CMDS   = 850;
    localparam int MAX_GAP       = 17;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_last;
        logic              rx_ready;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_ready;
    } spi_cmd_t;

    typedef struct packed {
        logic              wr_acc;
        logic              rd_valid;
        logic [BYTE_W-1:0] rd_data;
        logic              snd_valid;
        logic [BYTE_W-1:0] snd_data;
        logic              dropped;
        logic              cs;
    } spi_status_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Command stream and predicted status words
    spi_cmd_t    spi_cmd_q[$];
    spi_status_t spi_status_q[$];
    spi_cmd_t    cur_cmd;
    int          cmds_total    = 0;
    int          cmds_counted  = 0;
    int          cmds_accepted = 0;
    int          status_seen   = 0;
    int          fail_cnt      = 0;

    // Shadow copy of the rings, pointers, send enable and chip select
    logic [BYTE_W-1:0] tx_ring [TX_RING_DEPTH];
    logic [BYTE_W-1:0] rx_ring [RX_RING_DEPTH];
    int                tx_head, tx_tail, rx_head, rx_tail;
    logic              send_en;
    logic              cs_level;

    // Pacing state of both sides
    int   tx_gap      = 0;
    int   rx_stall    = 0;
    bit   send_fast   = 1'b0;
    bit   recv_fast   = 1'b0;
    int   hold_left   = 0;
    int   hold_starts = 0;
    int   idle_cycles = 0;

    spi_master_ring_buffer_cs_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Apply one command to the shadow rings and return the status it produces
    function automatic spi_status_t predict_ring_status(spi_cmd_t c);
        spi_status_t r;
        int          nxt;
        r = '0;
        case (c.kind)
            KIND_PUSH:
            begin
                nxt      = (tx_head + 1) % TX_RING_DEPTH;
                cs_level = 1'b0;
                if (nxt != tx_tail)
                begin
                    tx_ring[tx_head] = c.tx_byte;
                    tx_head          = nxt;
                    r.wr_acc         = 1'b1;
                end
                if (c.tx_last)
                    send_en = 1'b1;
            end
            KIND_READ:
            begin
                if (rx_head != rx_tail)
                begin
                    r.rd_valid = 1'b1;
                    r.rd_data  = rx_ring[rx_tail];
                    rx_tail    = (rx_tail + 1) % RX_RING_DEPTH;
                end
            end
            KIND_SERVICE:
            begin
                // store the received byte first, drop it on a full ring
                if (c.rx_ready)
                begin
                    nxt = (rx_head + 1) % RX_RING_DEPTH;
                    if (nxt != rx_tail)
                    begin
                        rx_ring[rx_head] = c.rx_byte;
                        rx_head          = nxt;
                    end
                    else
                        r.dropped = 1'b1;
                end
                // then feed the shifter or close the burst
                if (c.tx_ready && send_en)
                begin
                    if (tx_head != tx_tail)
                    begin
                        r.snd_valid = 1'b1;
                        r.snd_data  = tx_ring[tx_tail];
                        tx_tail     = (tx_tail + 1) % TX_RING_DEPTH;
                    end
                    else
                    begin
                        send_en  = 1'b0;
                        cs_level = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.cs = cs_level;
        return r;
    endfunction

    function automatic int draw_gap(bit fast);
        return fast ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Command with every field random, kind fixed
    function automatic spi_cmd_t rand_cmd(logic [KIND_W-1:0] k);
        spi_cmd_t    c;
        logic [31:0] r;
        r          = $urandom;
        c          = r[$bits(spi_cmd_t)-1:0];
        c.kind     = k;
        c.tx_byte  = BYTE_W'($urandom);
        c.rx_byte  = BYTE_W'($urandom);
        return c;
    endfunction

    task automatic queue_cmd(spi_cmd_t c);
        spi_cmd_q.push_back(c);
        cmds_total++;
        if (c.kind != KIND_UNUSED)
            cmds_counted++;
    endtask

    task automatic queue_fixed(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] txb, logic last,
                               logic rxr, logic [BYTE_W-1:0] rxb, logic txr);
        spi_cmd_t c;
        c = '{kind: k, tx_byte: txb, tx_last: last, rx_ready: rxr, rx_byte: rxb,
              tx_ready: txr};
        queue_cmd(c);
    endtask

    // Drive command words; hold while stalled, idle between words
    always @(posedge clk)
    begin : cmd_driver
        spi_cmd_t             nxt;
        logic [S_TDATA_W-1:0] tdata_v;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                spi_status_q.push_back(predict_ring_status(cur_cmd));
                cmds_accepted++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the current word
            end
            else if (tx_gap != 0)
            begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (spi_cmd_q.size() != 0)
            begin
                nxt = spi_cmd_q.pop_front();
                if ($urandom_range(0, 39) == 0)
                    send_fast = !send_fast;
                tdata_v = '0;
                tdata_v[IN_TX_BYTE_LSB +: BYTE_W] = nxt.tx_byte;
                tdata_v[IN_RX_READY_BIT]          = nxt.rx_ready;
                tdata_v[IN_RX_BYTE_LSB +: BYTE_W] = nxt.rx_byte;
                tdata_v[IN_TX_READY_BIT]          = nxt.tx_ready;
                cur_cmd  <= nxt;
                s_tdata  <= tdata_v;
                s_tuser  <= nxt.kind;
                s_tlast  <= nxt.tx_last;
                s_tvalid <= 1'b1;
                tx_gap   <= draw_gap(send_fast);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Check status words against the oldest prediction; pace m_tready
    always @(posedge clk)
    begin : status_monitor
        spi_status_t got;
        spi_status_t exp;
        int          wait_n;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            wait_n = rx_stall;
            if (m_tvalid && m_tready)
            begin
                got.wr_acc    = m_tdata[OUT_WR_ACC_BIT];
                got.rd_valid  = m_tdata[OUT_RD_VALID_BIT];
                got.rd_data   = m_tdata[OUT_RD_DATA_LSB +: BYTE_W];
                got.snd_valid = m_tdata[OUT_SND_VALID_BIT];
                got.snd_data  = m_tdata[OUT_SND_DATA_LSB +: BYTE_W];
                got.dropped   = m_tdata[OUT_DROP_BIT];
                got.cs        = m_tdata[OUT_CS_BIT];
                if (spi_status_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected status word %h", m_tdata);
                end
                else
                begin
                    exp = spi_status_q.pop_front();
                    if (got !== exp)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display("status %0d mismatch", status_seen);
                            $display("  exp acc=%b rv=%b rd=%h sv=%b sd=%h drop=%b cs=%b",
                                     exp.wr_acc, exp.rd_valid, exp.rd_data, exp.snd_valid,
                                     exp.snd_data, exp.dropped, exp.cs);
                            $display("  got acc=%b rv=%b rd=%h sv=%b sd=%h drop=%b cs=%b",
                                     got.wr_acc, got.rd_valid, got.rd_data, got.snd_valid,
                                     got.snd_data, got.dropped, got.cs);
                        end
                    end
                end
                status_seen <= status_seen + 1;
                if ($urandom_range(0, 39) == 0)
                    recv_fast = !recv_fast;
                wait_n = draw_gap(recv_fast);
            end
            else if (wait_n != 0)
                wait_n--;
            rx_stall <= wait_n;
            m_tready <= (wait_n == 0) && (hold_left == 0);
        end
    end

    // Hold off the output twice for a long stretch so the core backs up
    always @(posedge clk)
    begin : long_hold
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_starts < 2 && status_seen >= 200 + 400 * hold_starts)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_starts <= hold_starts + 1;
        end
    end

    // Abort when no word moves on either side for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        spi_cmd_t c;
        int       sel;
        int       n;
        int       m;

        tx_head  = 0;
        tx_tail  = 0;
        rx_head  = 0;
        rx_tail  = 0;
        send_en  = 1'b1;
        cs_level = 1'b1;

        // Directed: empty read, service while idle, burst with extremes,
        // ready while disabled, unused kind
        queue_fixed(KIND_READ,    8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1);
        queue_fixed(KIND_READ,    8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
        queue_fixed(KIND_PUSH,    8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_fixed(KIND_PUSH,    8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
        queue_fixed(KIND_SERVICE, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b1);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        queue_fixed(KIND_PUSH,    8'hA5, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        queue_fixed(KIND_PUSH,    8'h5A, 1'b1, 1'b0, 8'h00, 1'b0);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        queue_fixed(KIND_SERVICE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        queue_fixed(KIND_UNUSED,  8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
        queue_fixed(KIND_READ,    8'h00, 1'b0, 1'b0, 8'h00, 1'b0);

        // Random: write bursts, receive fills, mixed traffic and noise
        n = cmds_counted + RANDOM_CMDS;
        while (cmds_counted < n)
        begin
            sel = $urandom_range(0, 99);
            m   = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
            if (sel < 35)
            begin
                // burst of pushes, usually closed by a last byte, then drain
                for (int i = 0; i < m; i++)
                begin
                    c         = rand_cmd(KIND_PUSH);
                    c.tx_last = (i == m - 1) && ($urandom_range(0, 9) != 0);
                    queue_cmd(c);
                end
                for (int i = 0; i < m + $urandom_range(0, 3); i++)
                begin
                    c          = rand_cmd(KIND_SERVICE);
                    c.tx_ready = ($urandom_range(0, 7) != 0);
                    c.rx_ready = ($urandom_range(0, 3) == 0);
                    queue_cmd(c);
                end
            end
            else if (sel < 60)
            begin
                // fill the receive ring, then read part or all of it back
                for (int i = 0; i < m; i++)
                begin
                    c          = rand_cmd(KIND_SERVICE);
                    c.rx_ready = 1'b1;
                    c.tx_ready = ($urandom_range(0, 3) == 0);
                    queue_cmd(c);
                end
                for (int i = 0; i < $urandom_range(0, m + 2); i++)
                    queue_cmd(rand_cmd(KIND_READ));
            end
            else if (sel < 85)
            begin
                for (int i = 0; i < $urandom_range(4, 24); i++)
                    queue_cmd(rand_cmd(KIND_W'($urandom_range(0, 2))));
            end
            else
                queue_cmd(rand_cmd(KIND_W'($urandom_range(0, 3))));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted != cmds_total || spi_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0 && spi_status_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/smrb_pkg.sv
hw/rtl/spi_master_ring_buffer_cs_core.sv
verif/spi_master_ring_buffer_cs_core_tb.sv
